[src/h2ps2_pkg.sv]
// Shared types, constants and lookup tables of the HID to PS/2 set-2 translator.
// No dependencies; imported by h2ps2_front, h2ps2_cmd_queue, h2ps2_back and the top level.
package h2ps2_pkg;

    localparam logic [7:0] PFX_EXT     = 8'hE0;
    localparam logic [7:0] PFX_BRK     = 8'hF0;
    localparam logic [7:0] PFX_PAUSE   = 8'hE1;
    localparam logic [7:0] USAGE_PRTSC = 8'h46;
    localparam logic [7:0] USAGE_PAUSE = 8'h48;

    localparam int CMD_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        CMD_KEY,
        CMD_MODS,
        CMD_SEQ
    } cmd_kind_t;

    typedef enum logic [1:0] {
        SEQ_PRT_MAKE,
        SEQ_PRT_BRK,
        SEQ_PAUSE
    } seq_id_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        rel;
        logic        ext;
        logic [7:0]  data;
        seq_id_t     seq;
    } cmd_t;

    localparam logic [7:0] USAGE_MAP [256] = '{
        8'h00,8'h00,8'hfc,8'h00,8'h1c,8'h32,8'h21,8'h23,
        8'h24,8'h2b,8'h34,8'h33,8'h43,8'h3b,8'h42,8'h4b,
        8'h3a,8'h31,8'h44,8'h4d,8'h15,8'h2d,8'h1b,8'h2c,
        8'h3c,8'h2a,8'h1d,8'h22,8'h35,8'h1a,8'h16,8'h1e,
        8'h26,8'h25,8'h2e,8'h36,8'h3d,8'h3e,8'h46,8'h45,
        8'h5a,8'h76,8'h66,8'h0d,8'h29,8'h4e,8'h55,8'h54,
        8'h5b,8'h5d,8'h5d,8'h4c,8'h52,8'h0e,8'h41,8'h49,
        8'h4a,8'h58,8'h05,8'h06,8'h04,8'h0c,8'h03,8'h0b,
        8'h83,8'h0a,8'h01,8'h09,8'h78,8'h07,8'hfe,8'h7e,
        8'hfe,8'h70,8'h6c,8'h7d,8'h71,8'h69,8'h7a,8'h74,
        8'h6b,8'h72,8'h75,8'h77,8'h4a,8'h7c,8'h7b,8'h79,
        8'h5a,8'h69,8'h72,8'h7a,8'h6b,8'h73,8'h74,8'h6c,
        8'h75,8'h7d,8'h70,8'h71,8'h61,8'h2f,8'h37,8'h0f,
        8'h08,8'h10,8'h18,8'h20,8'h28,8'h30,8'h38,8'h40,
        8'h48,8'h50,8'h57,8'h5f,8'hff,8'hff,8'hff,8'hff,
        8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
        8'hff,8'hff,8'hff,8'hff,8'hff,8'h6d,8'hff,8'h51,
        8'h13,8'h6a,8'h64,8'h67,8'h27,8'hff,8'hff,8'hff,
        8'hf2,8'hf1,8'h63,8'h62,8'h5f,8'hff,8'hff,8'hff,
        8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
        8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
        8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
        8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
        8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
        8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
        8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
        8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
        8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
        8'h14,8'h12,8'h11,8'h1f,8'h14,8'h59,8'h11,8'h27,
        8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
        8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
        8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff
    };

    localparam logic [7:0] MOD_MAP [8] = '{
        8'h14, 8'h12, 8'h11, 8'h1f, 8'h14, 8'h59, 8'h11, 8'h27
    };

    // Modifiers that need the E0 prefix: right GUI, right ctrl, right alt, left GUI.
    localparam logic [7:0] MOD_EXT = 8'b1101_1000;

    localparam logic [7:0] SEQ_PRT_MAKE_ROM [8] = '{
        8'hE0, 8'h12, 8'hE0, 8'h7C, 8'h00, 8'h00, 8'h00, 8'h00
    };
    localparam logic [7:0] SEQ_PRT_BRK_ROM [8] = '{
        8'hE0, 8'hF0, 8'h7C, 8'hE0, 8'hF0, 8'h12, 8'h00, 8'h00
    };
    localparam logic [7:0] SEQ_PAUSE_ROM [8] = '{
        8'hE1, 8'h14, 8'h77, 8'hE1, 8'hF0, 8'h14, 8'hF0, 8'h77
    };

    function automatic logic usage_is_ext(input logic [7:0] u);
        return (u >= 8'h49 && u <= 8'h52) || u == 8'h54 || u == 8'h58 ||
               u == 8'h65 || u == 8'h66 || u == 8'he3 || u == 8'he4 ||
               u == 8'he6 || u == 8'he7;
    endfunction

    function automatic logic [7:0] seq_byte(input seq_id_t s, input logic [2:0] i);
        logic [7:0] b;
        case (s)
            SEQ_PRT_MAKE: b = SEQ_PRT_MAKE_ROM[i];
            SEQ_PRT_BRK:  b = SEQ_PRT_BRK_ROM[i];
            SEQ_PAUSE:    b = SEQ_PAUSE_ROM[i];
            default:      b = 8'h00;
        endcase
        return b;
    endfunction

    // Index of the final byte of each fixed sequence.
    function automatic logic [2:0] seq_last_idx(input seq_id_t s);
        logic [2:0] n;
        case (s)
            SEQ_PRT_MAKE: n = 3'd3;
            SEQ_PRT_BRK:  n = 3'd5;
            SEQ_PAUSE:    n = 3'd7;
            default:      n = 3'd0;
        endcase
        return n;
    endfunction

    // Position of the lowest set bit; zero when no bit is set.
    function automatic logic [2:0] low_idx(input logic [7:0] b);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (b[i]) begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

endpackage

[src/h2ps2_front.sv]
// Front end: accepts key events and classifies them into translation commands.
// Depends on h2ps2_pkg for the usage table and command types.
module h2ps2_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_action,
    input  logic              s_released,
    input  logic [7:0]        s_code,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output h2ps2_pkg::cmd_t   cmd
);
    import h2ps2_pkg::*;

    logic produces;

    // Events that give no bytes are taken and dropped here.
    always_comb begin
        produces  = 1'b1;
        cmd.kind  = CMD_KEY;
        cmd.rel   = s_released;
        cmd.ext   = 1'b0;
        cmd.data  = s_code;
        cmd.seq   = SEQ_PRT_MAKE;
        if (s_code == 8'h00) begin
            produces = 1'b0;
        end else if (s_action) begin
            cmd.kind = CMD_MODS;
        end else if (s_code == USAGE_PRTSC) begin
            cmd.kind = CMD_SEQ;
            cmd.seq  = s_released ? SEQ_PRT_BRK : SEQ_PRT_MAKE;
        end else if (s_code == USAGE_PAUSE) begin
            cmd.kind = CMD_SEQ;
            cmd.seq  = SEQ_PAUSE;
            produces = !s_released;
        end else begin
            cmd.ext  = usage_is_ext(s_code);
            cmd.data = USAGE_MAP[s_code];
        end
    end

    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid && produces;

endmodule

[src/h2ps2_cmd_queue.sv]
// Short command queue in flip-flops between the front end and the byte sequencer.
// Depends on h2ps2_pkg for the command type.
module h2ps2_cmd_queue #(
    parameter int DEPTH = h2ps2_pkg::CMD_QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  h2ps2_pkg::cmd_t   wr_cmd,
    output logic              rd_valid,
    input  logic              rd_ready,
    output h2ps2_pkg::cmd_t   rd_cmd
);
    import h2ps2_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign wr_ready = count_reg != CNT_W'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_cmd   = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

[src/h2ps2_back.sv]
// Back end: steps through one command a byte at a time into a registered output stage.
// Depends on h2ps2_pkg for tables, sequence ROMs and command types.
module h2ps2_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  h2ps2_pkg::cmd_t   cmd,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_last
);
    import h2ps2_pkg::*;

    typedef enum logic [1:0] {
        PH_EXT,
        PH_BRK,
        PH_CODE
    } phase_t;

    function automatic phase_t first_phase(input logic ext, input logic rel);
        return ext ? PH_EXT : (rel ? PH_BRK : PH_CODE);
    endfunction

    logic        busy_reg,  busy_next;
    cmd_kind_t   kind_reg,  kind_next;
    logic        rel_reg,   rel_next;
    logic [7:0]  val_reg,   val_next;
    logic [7:0]  bits_reg,  bits_next;
    seq_id_t     seq_reg,   seq_next;
    logic [2:0]  idx_reg,   idx_next;
    phase_t      phase_reg, phase_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        last_reg,  last_next;

    logic        out_free, emit, load;
    logic        cur_last;
    logic [7:0]  cur_val, cur_byte;
    logic [7:0]  mod_low, mod_rest;
    logic [2:0]  mod_idx, rest_idx, head_idx;

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = busy_reg && out_free;
    assign load      = cmd_valid && (!busy_reg || (emit && cur_last));
    assign cmd_ready = load;

    // Byte selection for the current step.
    always_comb begin
        mod_low  = bits_reg & (~bits_reg + 8'd1);
        mod_rest = bits_reg & ~mod_low;
        mod_idx  = low_idx(bits_reg);
        rest_idx = low_idx(mod_rest);
        head_idx = low_idx(cmd.data);

        if (kind_reg == CMD_MODS) begin
            cur_val = MOD_MAP[mod_idx];
        end else begin
            cur_val = val_reg;
        end

        cur_byte = cur_val;
        cur_last = 1'b0;
        case (kind_reg)
            CMD_SEQ: begin
                cur_byte = seq_byte(seq_reg, idx_reg);
                cur_last = idx_reg == seq_last_idx(seq_reg);
            end
            CMD_KEY, CMD_MODS: begin
                case (phase_reg)
                    PH_EXT:  cur_byte = PFX_EXT;
                    PH_BRK:  cur_byte = PFX_BRK;
                    PH_CODE: begin
                        cur_byte = cur_val;
                        cur_last = (kind_reg == CMD_KEY) || (mod_rest == 8'h00);
                    end
                    default: cur_byte = cur_val;
                endcase
            end
            default: cur_last = 1'b1;
        endcase
    end

    // Next state of the sequencer and the output stage.
    always_comb begin
        busy_next     = busy_reg;
        kind_next     = kind_reg;
        rel_next      = rel_reg;
        val_next      = val_reg;
        bits_next     = bits_reg;
        seq_next      = seq_reg;
        idx_next      = idx_reg;
        phase_next    = phase_reg;
        m_valid_next  = m_valid_reg;
        out_byte_next = out_byte_reg;
        last_next     = last_reg;

        if (out_free) begin
            m_valid_next  = emit;
            out_byte_next = cur_byte;
            last_next     = cur_last;
        end

        if (emit) begin
            idx_next = idx_reg + 3'd1;
            case (phase_reg)
                PH_EXT:  phase_next = rel_reg ? PH_BRK : PH_CODE;
                PH_BRK:  phase_next = PH_CODE;
                PH_CODE: begin
                    bits_next  = mod_rest;
                    phase_next = first_phase(MOD_EXT[rest_idx], rel_reg);
                end
                default: phase_next = PH_CODE;
            endcase
            if (cur_last) begin
                busy_next = 1'b0;
            end
        end

        if (load) begin
            busy_next = 1'b1;
            kind_next = cmd.kind;
            rel_next  = cmd.rel;
            val_next  = cmd.data;
            bits_next = cmd.data;
            seq_next  = cmd.seq;
            idx_next  = 3'd0;
            if (cmd.kind == CMD_MODS) begin
                phase_next = first_phase(MOD_EXT[head_idx], cmd.rel);
            end else begin
                phase_next = first_phase(cmd.ext, cmd.rel);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
        kind_reg     <= kind_next;
        rel_reg      <= rel_next;
        val_reg      <= val_next;
        bits_reg     <= bits_next;
        seq_reg      <= seq_next;
        idx_reg      <= idx_next;
        phase_reg    <= phase_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_last     = last_reg;

`ifndef SYNTHESIS
    // A modifier command in progress always has a key left to send.
    a_mods_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && kind_reg == CMD_MODS |-> bits_reg != 8'h00)
        else $error("modifier command active with empty bitmap");

    // A fixed sequence never runs past its final byte.
    a_seq_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && kind_reg == CMD_SEQ |-> idx_reg <= seq_last_idx(seq_reg))
        else $error("fixed sequence index past its end");

    // Sending a byte that is not the last keeps the command in progress.
    a_busy_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && !cur_last |=> busy_reg)
        else $error("command dropped before its last byte");

    // Sending the last byte with no command waiting leaves the sequencer idle with that byte presented as last.
    a_last_from_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && cur_last && !cmd_valid |=> !busy_reg && m_valid_reg && last_reg)
        else $error("last byte not presented at end of command");
`endif

endmodule

[src/hid_to_ps2_scancode_translator_unit.sv]
// Top level of the HID keyboard event to PS/2 scan code set 2 translator.
// Depends on h2ps2_pkg, h2ps2_front, h2ps2_cmd_queue and h2ps2_back.
//
//   Channel | Direction | Ports                                    | Moves
//   --------+-----------+------------------------------------------+------------------------
//   s_      | in        | s_valid s_ready s_action s_released s_code | one key event
//   m_      | out       | m_valid m_ready m_out_byte m_last          | one scan code byte
//
// An event is taken in the cycle it arrives whenever the command queue has room, and
// its classified command enters the queue at that same edge. The sequencer sends one
// byte per cycle while the m_ side is ready, from 1 to 20 bytes per event; the next
// command is loaded on the edge that sends the last byte of the current one, so
// back-to-back events leave no gap. From an idle block the first byte of an event is
// written to the queue, loaded into the sequencer and then into the output register.
// Events that give no bytes (usage zero, empty bitmap, Pause release) take one input
// transfer and nothing else. Reset (aresetn, synchronous, active low) empties the queue
// and the output stage. An m_ stall holds the output register and, once the queue is
// full, backs up into s_ready; the input side keeps taking events meanwhile.
module hid_to_ps2_scancode_translator_unit #(
    parameter int CMD_QUEUE_DEPTH = h2ps2_pkg::CMD_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic        s_released,
    input  logic [7:0]  s_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last
);
    import h2ps2_pkg::*;

    // Commands from the classifier into the queue.
    logic  front_valid, front_ready;
    cmd_t  front_cmd;

    // Commands from the queue into the byte sequencer.
    logic  back_valid, back_ready;
    cmd_t  back_cmd;

    h2ps2_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_released (s_released),
        .s_code     (s_code),
        .cmd_valid  (front_valid),
        .cmd_ready  (front_ready),
        .cmd        (front_cmd)
    );

    h2ps2_cmd_queue #(
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_cmd   (front_cmd),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_cmd   (back_cmd)
    );

    // The sequencer owns the output register, which parts the m_ side from the queue.
    h2ps2_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (back_valid),
        .cmd_ready  (back_ready),
        .cmd        (back_cmd),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

endmodule

[tb/hid_to_ps2_scancode_translator_unit_tb.sv]
// Self-checking testbench for the HID keyboard event to PS/2 set-2 scan code translator.
// Depends on h2ps2_pkg and hid_to_ps2_scancode_translator_unit; holds its own byte
// predictor and a scoreboard class, with random idling on both valid/ready channels.
module hid_to_ps2_scancode_translator_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import h2ps2_pkg::*;

    // Scan codes of HID usages 0x00 to 0x73. Usages above that are looked up by
    // the case statement in the scoreboard, and everything not listed there maps to FF.
    localparam logic [7:0] LOW_USAGE_SCANCODE [0:115] = '{
        8'h00, 8'h00, 8'hfc, 8'h00, 8'h1c, 8'h32, 8'h21, 8'h23,
        8'h24, 8'h2b, 8'h34, 8'h33, 8'h43, 8'h3b, 8'h42, 8'h4b,
        8'h3a, 8'h31, 8'h44, 8'h4d, 8'h15, 8'h2d, 8'h1b, 8'h2c,
        8'h3c, 8'h2a, 8'h1d, 8'h22, 8'h35, 8'h1a, 8'h16, 8'h1e,
        8'h26, 8'h25, 8'h2e, 8'h36, 8'h3d, 8'h3e, 8'h46, 8'h45,
        8'h5a, 8'h76, 8'h66, 8'h0d, 8'h29, 8'h4e, 8'h55, 8'h54,
        8'h5b, 8'h5d, 8'h5d, 8'h4c, 8'h52, 8'h0e, 8'h41, 8'h49,
        8'h4a, 8'h58, 8'h05, 8'h06, 8'h04, 8'h0c, 8'h03, 8'h0b,
        8'h83, 8'h0a, 8'h01, 8'h09, 8'h78, 8'h07, 8'hfe, 8'h7e,
        8'hfe, 8'h70, 8'h6c, 8'h7d, 8'h71, 8'h69, 8'h7a, 8'h74,
        8'h6b, 8'h72, 8'h75, 8'h77, 8'h4a, 8'h7c, 8'h7b, 8'h79,
        8'h5a, 8'h69, 8'h72, 8'h7a, 8'h6b, 8'h73, 8'h74, 8'h6c,
        8'h75, 8'h7d, 8'h70, 8'h71, 8'h61, 8'h2f, 8'h37, 8'h0f,
        8'h08, 8'h10, 8'h18, 8'h20, 8'h28, 8'h30, 8'h38, 8'h40,
        8'h48, 8'h50, 8'h57, 8'h5f
    };

    // Modifier bits whose scan code needs the E0 prefix: left GUI, right ctrl,
    // right alt and right GUI.
    localparam logic [7:0] MOD_NEEDS_E0 = 8'b1101_1000;

    // The fixed sequences of Print Screen and Pause.
    localparam logic [7:0] PRTSC_MAKE_BYTES [0:3]  = '{8'hE0, 8'h12, 8'hE0, 8'h7C};
    localparam logic [7:0] PRTSC_BREAK_BYTES [0:5] = '{8'hE0, 8'hF0, 8'h7C,
                                                       8'hE0, 8'hF0, 8'h12};
    localparam logic [7:0] PAUSE_MAKE_BYTES [0:7]  = '{8'hE1, 8'h14, 8'h77, 8'hE1,
                                                       8'hF0, 8'h14, 8'hF0, 8'h77};

    // Predicts the scan code bytes of every accepted key event and checks each
    // byte that leaves the block against the oldest one still pending.
    class ps2_byte_scoreboard;

        typedef struct packed {
            logic [7:0] data;
            logic       last;
        } ps2_byte_t;

        ps2_byte_t pending_bytes[$];
        int        fail_count;

        function new();
            fail_count = 0;
        endfunction

        function logic [7:0] usage_scancode(logic [7:0] usage);
            logic [7:0] sc;
            if (usage <= 8'h73) begin
                sc = LOW_USAGE_SCANCODE[usage];
            end else begin
                case (usage)
                    8'h85: sc = 8'h6d;
                    8'h87: sc = 8'h51;
                    8'h88: sc = 8'h13;
                    8'h89: sc = 8'h6a;
                    8'h8a: sc = 8'h64;
                    8'h8b: sc = 8'h67;
                    8'h8c: sc = 8'h27;
                    8'h90: sc = 8'hf2;
                    8'h91: sc = 8'hf1;
                    8'h92: sc = 8'h63;
                    8'h93: sc = 8'h62;
                    8'h94: sc = 8'h5f;
                    8'he0: sc = 8'h14;
                    8'he1: sc = 8'h12;
                    8'he2: sc = 8'h11;
                    8'he3: sc = 8'h1f;
                    8'he4: sc = 8'h14;
                    8'he5: sc = 8'h59;
                    8'he6: sc = 8'h11;
                    8'he7: sc = 8'h27;
                    default: sc = 8'hff;
                endcase
            end
            return sc;
        endfunction

        function bit usage_needs_e0(logic [7:0] usage);
            return (usage >= 8'h49 && usage <= 8'h52) || usage == 8'h54 ||
                   usage == 8'h58 || usage == 8'h65 || usage == 8'h66 ||
                   usage == 8'he3 || usage == 8'he4 || usage == 8'he6 ||
                   usage == 8'he7;
        endfunction

        function void add_event(logic action, logic rel, logic [7:0] code);
            logic [7:0] seq[$];
            ps2_byte_t  pb;
            if (code == 8'h00) begin
                return;
            end
            if (action) begin
                for (int i = 0; i < 8; i++) begin
                    if (code[i]) begin
                        if (MOD_NEEDS_E0[i]) seq.push_back(PFX_EXT);
                        if (rel) seq.push_back(PFX_BRK);
                        seq.push_back(usage_scancode(8'he0 + 8'(i)));
                    end
                end
            end else if (code == USAGE_PRTSC) begin
                if (rel) begin
                    foreach (PRTSC_BREAK_BYTES[i]) seq.push_back(PRTSC_BREAK_BYTES[i]);
                end else begin
                    foreach (PRTSC_MAKE_BYTES[i]) seq.push_back(PRTSC_MAKE_BYTES[i]);
                end
            end else if (code == USAGE_PAUSE) begin
                // Pause has no break sequence.
                if (!rel) begin
                    foreach (PAUSE_MAKE_BYTES[i]) seq.push_back(PAUSE_MAKE_BYTES[i]);
                end
            end else begin
                if (usage_needs_e0(code)) seq.push_back(PFX_EXT);
                if (rel) seq.push_back(PFX_BRK);
                seq.push_back(usage_scancode(code));
            end
            foreach (seq[i]) begin
                pb.data = seq[i];
                pb.last = (i == seq.size() - 1);
                pending_bytes.push_back(pb);
            end
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            ps2_byte_t want;
            if (pending_bytes.size() == 0) begin
                $error("unexpected scan code byte: out_byte %h last %b", data, last);
                fail_count++;
                return;
            end
            want = pending_bytes.pop_front();
            if (data !== want.data) begin
                $error("out_byte mismatch: expected %h actual %h", want.data, data);
                fail_count++;
            end
            if (last !== want.last) begin
                $error("last mismatch: expected %b actual %b", want.last, last);
                fail_count++;
            end
        endfunction

    endclass

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic       s_action   = 1'b0;
    logic       s_released = 1'b0;
    logic [7:0] s_code     = 8'h00;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last;

    ps2_byte_scoreboard sb;

    // While a steady flag is set, that side of the block never idles.
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    // The stimulus process bumps this count to ask the receiver for one long
    // hold-off; the receiver counts the held cycles itself.
    int rx_hold_requests = 0;
    int rx_hold_served   = 0;
    int rx_hold_left     = 0;

    hid_to_ps2_scancode_translator_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_released (s_released),
        .s_code     (s_code),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

    always #4 aclk = ~aclk;

    // Watches both channels at every rising edge. Since the block and the
    // testbench both update through nonblocking assignments, the values read
    // here are the ones present just before the edge. The input transfer is
    // noted before the output transfer is checked, so an event's bytes are
    // always predicted before any of them can be compared.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.add_event(s_action, s_released, s_code);
            end
            if (m_valid && m_ready) begin
                sb.check_byte(m_out_byte, m_last);
            end
        end
    end

    // Receiver: m_ready is low with a probability of about 36 percent, always high in
    // steady stretches, and low for a long counted stretch when a hold-off is
    // requested. That hold-off lets the command queue fill and stall s_ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            m_ready      <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_hold_served != rx_hold_requests) begin
            m_ready        <= 1'b0;
            rx_hold_served <= rx_hold_served + 1;
            rx_hold_left   <= 160;
        end else if (rx_steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 36);
        end
    end

    // Offers one key event and returns at the edge that takes it. Afterwards the
    // sender may go idle for a random number of cycles. When it does not, valid
    // simply stays high and the next call changes only the payload.
    task automatic send_event(input logic action, input logic rel, input logic [7:0] code);
        s_valid    <= 1'b1;
        s_action   <= action;
        s_released <= rel;
        s_code     <= code;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!tx_steady && $urandom_range(99) < 36) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 36);
        end
    endtask

    // Draws one event. Most are usages that translate to real keys or
    // modifier bitmaps, with the special keys, zero codes and arbitrary codes
    // mixed in so that unmapped table entries come up as well.
    task automatic send_random_event();
        int         pick;
        logic       rel;
        logic [7:0] code;
        pick = $urandom_range(99);
        rel  = 1'($urandom_range(1));
        if (pick < 10) begin
            case ($urandom_range(2))
                0:       code = USAGE_PRTSC;
                1:       code = USAGE_PAUSE;
                default: code = 8'h00;
            endcase
            send_event(1'b0, rel, code);
        end else if (pick < 45) begin
            code = 8'($urandom_range(8'h73, 8'h01));
            send_event(1'b0, rel, code);
        end else if (pick < 55) begin
            code = 8'($urandom_range(8'he7, 8'he0));
            send_event(1'b0, rel, code);
        end else if (pick < 68) begin
            code = 8'($urandom);
            send_event(1'b0, rel, code);
        end else if (pick < 92) begin
            code = 8'($urandom);
            send_event(1'b1, rel, code);
        end else begin
            // Single modifier bits, and now and then the full bitmap.
            code = ($urandom_range(3) == 0) ? 8'hff : (8'h01 << $urandom_range(7));
            send_event(1'b1, rel, code);
        end
    endtask

    // Stops offering events, lets the monitor note the last transfer, then
    // waits until every predicted byte has left the block.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_bytes.size() != 0) @(posedge aclk);
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed events: codes and bitmaps of zero, both fixed sequences in both
        // directions, the full bitmap, plain and E0 keys, and unmapped entries.
        send_event(1'b0, 1'b0, 8'h00);
        send_event(1'b0, 1'b1, 8'h00);
        send_event(1'b1, 1'b0, 8'h00);
        send_event(1'b1, 1'b1, 8'h00);
        send_event(1'b0, 1'b0, USAGE_PRTSC);
        send_event(1'b0, 1'b1, USAGE_PRTSC);
        send_event(1'b0, 1'b0, USAGE_PAUSE);
        send_event(1'b0, 1'b1, USAGE_PAUSE);
        send_event(1'b1, 1'b1, 8'hff);
        send_event(1'b1, 1'b0, 8'hff);
        send_event(1'b1, 1'b0, 8'h01);
        send_event(1'b1, 1'b1, 8'h80);
        send_event(1'b1, 1'b0, USAGE_PRTSC);
        send_event(1'b0, 1'b0, 8'h04);
        send_event(1'b0, 1'b1, 8'h04);
        send_event(1'b0, 1'b0, 8'h4f);
        send_event(1'b0, 1'b1, 8'h52);
        send_event(1'b0, 1'b1, 8'he3);
        send_event(1'b0, 1'b0, 8'h01);
        send_event(1'b0, 1'b1, 8'h02);
        send_event(1'b0, 1'b1, 8'hff);
        send_event(1'b0, 1'b0, 8'h54);
        send_event(1'b0, 1'b0, 8'h58);
        send_event(1'b0, 1'b1, 8'h66);

        // The sender pauses here until every byte of the directed part is out.
        wait_for_drain();

        // A stretch with no idling on either side, so that events follow back to
        // back and the sequencer has to chain commands without a gap.
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (40) send_random_event();
        rx_steady = 1'b0;

        // The receiver holds off for a long stretch while the sender keeps
        // offering events, so the queue fills and s_ready falls.
        rx_hold_requests++;
        repeat (30) send_random_event();
        tx_steady = 1'b0;
        wait_for_drain();

        repeat (160) send_random_event();

        // Let the last bytes out, then allow some extra cycles in which any
        // stray byte would be flagged by the monitor.
        wait_for_drain();
        repeat (50) @(posedge aclk);

        if (sb.fail_count == 0 && sb.pending_bytes.size() == 0) begin
            $display("[hid_to_ps2_scancode_translator_unit] OK");
        end else begin
            $display("[hid_to_ps2_scancode_translator_unit] ERROR");
        end
        $finish;
    end

    // Safety net in case a handshake never completes.
    initial begin
        #2_000_000;
        $display("[hid_to_ps2_scancode_translator_unit] ERROR");
        $finish;
    end

endmodule
